// ===== src/c8ie_pkg.sv =====
// shared types, codes and constant tables of the chip-8 execute unit
// used by c8ie_mem, c8ie_alu and chip8_instruction_execute_unit
package c8ie_pkg;

    localparam int MEM_DEPTH = 4096;
    localparam int MEM_AW = 12;
    localparam int FONT_LEN = 80;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int ROM_START_DEF = 512;
    localparam int FONT_BASE_DEF = 80;

    // item kinds on the op field
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef enum logic [3:0] {
        ALU_PASS_B,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD,
        ALU_SUB,
        ALU_RSUB,
        ALU_SHR,
        ALU_SHL
    } alu_op_t;

    typedef struct packed {
        alu_op_t    op;
        logic [7:0] a;
        logic [7:0] b;
    } alu_ctrl_t;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
        logic       eq;
    } alu_stat_t;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [MEM_AW-1:0] raddr;
    } mem_req_t;

    localparam logic [7:0] GLYPHS [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] glyph(input logic [6:0] idx);
        glyph = GLYPHS[idx];
    endfunction

    // decimal digits of a byte: compare-subtract for hundreds, reciprocal for tens
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [7:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem = (h == 2'd2) ? v - 8'd200 : ((h == 2'd1) ? v - 8'd100 : v);
        prod = {8'b0, rem[6:0]} * 15'd205;
        t = prod[14:11];
        o = rem - ({4'b0, t} * 8'd10);
        case (sel)
            2'd0:    bcd_digit = {6'b0, h};
            2'd1:    bcd_digit = {4'b0, t};
            default: bcd_digit = o;
        endcase
    endfunction

endpackage

// ===== src/c8ie_mem.sv =====
// 4 KB byte memory with registered read and a clearing pass that loads the font
// depends on c8ie_pkg
module c8ie_mem #(
    parameter int FONT_BASE = c8ie_pkg::FONT_BASE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  c8ie_pkg::mem_req_t        req,
    output logic [7:0]                rdata,
    output logic                      init_done
);

    logic [7:0] mem [c8ie_pkg::MEM_DEPTH];
    logic [c8ie_pkg::MEM_AW-1:0] init_cnt_reg;
    logic init_done_reg;
    logic [c8ie_pkg::MEM_AW-1:0] font_off;
    logic in_font;
    logic [7:0] init_byte;
    logic [7:0] rdata_reg;

    assign font_off = init_cnt_reg - c8ie_pkg::MEM_AW'(FONT_BASE);
    assign in_font = (init_cnt_reg >= c8ie_pkg::MEM_AW'(FONT_BASE))
                     && (font_off < c8ie_pkg::MEM_AW'(c8ie_pkg::FONT_LEN));
    assign init_byte = in_font ? c8ie_pkg::glyph(font_off[6:0]) : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
            init_done_reg <= 1'b0;
        end
        else if (!init_done_reg)
        begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if (init_cnt_reg == c8ie_pkg::MEM_AW'(c8ie_pkg::MEM_DEPTH - 1))
            begin
                init_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!init_done_reg)
        begin
            mem[init_cnt_reg] <= init_byte;
        end
        else if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
    assign init_done = init_done_reg;

endmodule

// ===== src/c8ie_alu.sv =====
// shared byte unit: logic ops, add, both subtracts, shifts, flag and equality
// depends on c8ie_pkg
module c8ie_alu (
    input  c8ie_pkg::alu_ctrl_t ctrl,
    output c8ie_pkg::alu_stat_t stat
);

    logic [8:0] sum;
    logic [8:0] diff;
    logic [8:0] rdiff;
    logic eq;

    assign sum = {1'b0, ctrl.a} + {1'b0, ctrl.b};
    assign diff = {1'b0, ctrl.a} - {1'b0, ctrl.b};
    assign rdiff = {1'b0, ctrl.b} - {1'b0, ctrl.a};
    assign eq = (ctrl.a == ctrl.b);

    always_comb
    begin
        stat.eq = eq;
        stat.flag = 1'b0;
        stat.res = ctrl.b;
        unique case (ctrl.op)
            c8ie_pkg::ALU_PASS_B: stat.res = ctrl.b;
            c8ie_pkg::ALU_OR:     stat.res = ctrl.a | ctrl.b;
            c8ie_pkg::ALU_AND:    stat.res = ctrl.a & ctrl.b;
            c8ie_pkg::ALU_XOR:    stat.res = ctrl.a ^ ctrl.b;
            c8ie_pkg::ALU_ADD:
            begin
                stat.res = sum[7:0];
                stat.flag = sum[8];
            end
            c8ie_pkg::ALU_SUB:
            begin
                stat.res = diff[7:0];
                stat.flag = !diff[8] && !eq;
            end
            c8ie_pkg::ALU_RSUB:
            begin
                stat.res = rdiff[7:0];
                stat.flag = !rdiff[8] && !eq;
            end
            c8ie_pkg::ALU_SHR:
            begin
                stat.res = {1'b0, ctrl.a[7:1]};
                stat.flag = ctrl.a[0];
            end
            c8ie_pkg::ALU_SHL:
            begin
                stat.res = {ctrl.a[6:0], 1'b0};
                stat.flag = ctrl.a[7];
            end
            default: stat.res = ctrl.b;
        endcase
    end

endmodule

// ===== src/chip8_instruction_execute_unit.sv =====
// chip-8 execute unit top level: sequencer, register file, call stack
// depends on c8ie_pkg, c8ie_mem and c8ie_alu
//
// usage
// - input channel (in_valid/in_ready) takes one word: op, addr, data, keys
//   op 0 runs the instruction at the pc, op 1 writes a memory byte,
//   op 2 reads a memory byte, op 3 only reports the state
// - output channel (out_valid/out_ready) returns one word per input word:
//   pc, opcode, index, read byte, timers, screen-clear and key-wait flags
// - one word is in flight at a time; in_ready is low from acceptance until
//   the result is taken
// - a write and op 3 go straight to the result state, a read passes the
//   read-wait state, and a plain instruction passes the fetch states through
//   the single memory read port, two register-file reads and one execute
//   through the shared byte unit ahead of the result state
// - fx33, fx55 and fx65 go on in S_BCD, S_ST and S_LD: one memory access
//   per cycle, the load needing a read and a writeback step per byte
// - after reset the memory is swept once over all 4096 bytes, writing zeros
//   and the font; in_ready stays low until the sweep finishes
// - a stalled receiver holds the result registers; nothing new is taken
module chip8_instruction_execute_unit #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH_DEF,
    parameter int ROM_START = c8ie_pkg::ROM_START_DEF,
    parameter int FONT_BASE = c8ie_pkg::FONT_BASE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [11:0] addr,
    input  logic [7:0]  data,
    input  logic [15:0] keys,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] pc_value,
    output logic [15:0] opcode_value,
    output logic [15:0] index_value,
    output logic [7:0]  read_data,
    output logic [7:0]  delay_value,
    output logic [7:0]  sound_value,
    output logic        clear_screen,
    output logic        waiting_key
);

    localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [11:0] {
        S_INIT   = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_RDWAIT = 12'b000000000100,
        S_F1     = 12'b000000001000,
        S_F2     = 12'b000000010000,
        S_RX     = 12'b000000100000,
        S_RY     = 12'b000001000000,
        S_EXEC   = 12'b000010000000,
        S_BCD    = 12'b000100000000,
        S_ST     = 12'b001000000000,
        S_LD     = 12'b010000000000,
        S_RESP   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [11:0]    pc_reg;
    logic [15:0]    index_reg;
    logic [7:0]     delay_reg;
    logic [7:0]     sound_reg;
    logic [SPW-1:0] sp_reg;
    logic [7:0]     v_reg [16];
    logic [11:0]    stack_mem [STACK_DEPTH];
    logic [11:0]    stack_q_reg;

    // per-item working registers
    logic [15:0] opcode_reg;
    logic [7:0]  hi_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rdata_reg;
    logic        clr_reg;
    logic        wait_reg;
    logic [3:0]  cnt_reg;
    logic        ld_phase_reg;

    logic accept;
    logic init_done;
    logic [7:0] mem_q;
    c8ie_pkg::mem_req_t mem_req;
    c8ie_pkg::alu_ctrl_t alu_ctrl;
    c8ie_pkg::alu_stat_t alu_stat;

    // instruction fields
    logic [3:0]  f_hi;
    logic [3:0]  f_x;
    logic [3:0]  f_y;
    logic [3:0]  f_n;
    logic [7:0]  f_kk;
    logic [11:0] f_nnn;

    logic [3:0]     rf_addr;
    logic [7:0]     rf_rdata;
    logic [SPW-1:0] sp_dec;
    logic [SPW-1:0] sp_inc;
    logic [11:0]    ptr_addr;
    logic           key_hit;
    logic           any_key;
    logic [3:0]     key_idx;
    logic [10:0]    vx_times5;
    logic           flag_op;

    assign f_hi = opcode_reg[15:12];
    assign f_x = opcode_reg[11:8];
    assign f_y = opcode_reg[7:4];
    assign f_n = opcode_reg[3:0];
    assign f_kk = opcode_reg[7:0];
    assign f_nnn = opcode_reg[11:0];

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);

    assign sp_dec = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sp_inc = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign ptr_addr = index_reg[11:0] + {8'b0, cnt_reg};

    // key lookups against the keypad captured at acceptance
    assign key_hit = (vx_reg[7:4] == 4'h0) && keys_reg[vx_reg[3:0]];
    assign any_key = (keys_reg != 16'h0000);
    always_comb
    begin
        key_idx = 4'h0;
        for (int i = 0; i < 16; i++)
        begin
            if (keys_reg[i])
            begin
                key_idx = 4'(i);
            end
        end
    end

    assign vx_times5 = {3'b0, vx_reg} + {1'b0, vx_reg, 2'b0};
    assign flag_op = (f_n == 4'h4) || (f_n == 4'h5) || (f_n == 4'h6)
                     || (f_n == 4'h7) || (f_n == 4'hE);

    // single register-file read port
    always_comb
    begin
        case (state_reg)
            S_RX:    rf_addr = f_x;
            S_RY:    rf_addr = (f_hi == 4'hB) ? 4'h0 : f_y;
            default: rf_addr = cnt_reg;
        endcase
    end
    assign rf_rdata = v_reg[rf_addr];

    // memory port control
    always_comb
    begin
        mem_req.we = 1'b0;
        mem_req.waddr = ptr_addr;
        mem_req.wdata = c8ie_pkg::bcd_digit(vx_reg, cnt_reg[1:0]);
        mem_req.raddr = pc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == c8ie_pkg::OP_WRITE)
                begin
                    mem_req.we = 1'b1;
                    mem_req.waddr = addr;
                    mem_req.wdata = data;
                end
                if (op == c8ie_pkg::OP_READ)
                begin
                    mem_req.raddr = addr;
                end
            end
            S_F1:  mem_req.raddr = pc_reg + 12'd1;
            S_BCD: mem_req.we = 1'b1;
            S_ST:
            begin
                mem_req.we = 1'b1;
                mem_req.wdata = rf_rdata;
            end
            S_LD:  mem_req.raddr = ptr_addr;
            default: mem_req.raddr = pc_reg;
        endcase
    end

    c8ie_mem #(
        .FONT_BASE(FONT_BASE)
    ) u_mem (
        .clk(clk),
        .rst_n(rst_n),
        .req(mem_req),
        .rdata(mem_q),
        .init_done(init_done)
    );

    // byte unit operands and operation
    always_comb
    begin
        alu_ctrl.a = vx_reg;
        alu_ctrl.b = vy_reg;
        alu_ctrl.op = c8ie_pkg::ALU_PASS_B;
        case (f_hi)
            4'h3, 4'h4: alu_ctrl.b = f_kk;
            4'h6: alu_ctrl.b = f_kk;
            4'h7:
            begin
                alu_ctrl.b = f_kk;
                alu_ctrl.op = c8ie_pkg::ALU_ADD;
            end
            4'h8:
            begin
                case (f_n)
                    4'h1:    alu_ctrl.op = c8ie_pkg::ALU_OR;
                    4'h2:    alu_ctrl.op = c8ie_pkg::ALU_AND;
                    4'h3:    alu_ctrl.op = c8ie_pkg::ALU_XOR;
                    4'h4:    alu_ctrl.op = c8ie_pkg::ALU_ADD;
                    4'h5:    alu_ctrl.op = c8ie_pkg::ALU_SUB;
                    4'h6:    alu_ctrl.op = c8ie_pkg::ALU_SHR;
                    4'h7:    alu_ctrl.op = c8ie_pkg::ALU_RSUB;
                    4'hE:    alu_ctrl.op = c8ie_pkg::ALU_SHL;
                    default: alu_ctrl.op = c8ie_pkg::ALU_PASS_B;
                endcase
            end
            4'hF:
            begin
                if (f_kk == 8'h07)
                begin
                    alu_ctrl.b = delay_reg;
                end
                else
                begin
                    alu_ctrl.b = {4'h0, key_idx};
                end
            end
            default: alu_ctrl.b = vy_reg;
        endcase
    end

    c8ie_alu u_alu (
        .ctrl(alu_ctrl),
        .stat(alu_stat)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: if (init_done) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == c8ie_pkg::OP_EXEC)
                    begin
                        state_next = S_F1;
                    end
                    else if (op == c8ie_pkg::OP_READ)
                    begin
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RDWAIT: state_next = S_RESP;
            S_F1:     state_next = S_F2;
            S_F2:     state_next = S_RX;
            S_RX:     state_next = S_RY;
            S_RY:     state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_RESP;
                if (f_hi == 4'hF)
                begin
                    case (f_kk)
                        8'h33:   state_next = S_BCD;
                        8'h55:   state_next = S_ST;
                        8'h65:   state_next = S_LD;
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_BCD: if (cnt_reg == 4'd2) state_next = S_RESP;
            S_ST:  if (cnt_reg == f_x) state_next = S_RESP;
            S_LD:  if (ld_phase_reg && cnt_reg == f_x) state_next = S_RESP;
            S_RESP: if (out_ready) state_next = S_IDLE;
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // architectural state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 12'(ROM_START);
            index_reg <= '0;
            delay_reg <= '0;
            sound_reg <= '0;
            sp_reg <= '0;
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= '0;
            end
            cnt_reg <= '0;
            ld_phase_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_F2: pc_reg <= pc_reg + 12'd2;
                S_EXEC:
                begin
                    cnt_reg <= '0;
                    ld_phase_reg <= 1'b0;
                    case (f_hi)
                        4'h0:
                        begin
                            if (opcode_reg == 16'h00EE)
                            begin
                                sp_reg <= sp_dec;
                                pc_reg <= stack_q_reg;
                            end
                        end
                        4'h1: pc_reg <= f_nnn;
                        4'h2:
                        begin
                            sp_reg <= sp_inc;
                            pc_reg <= f_nnn;
                        end
                        4'h3: if (alu_stat.eq) pc_reg <= pc_reg + 12'd2;
                        4'h4: if (!alu_stat.eq) pc_reg <= pc_reg + 12'd2;
                        4'h5: if (f_n == 4'h0 && alu_stat.eq) pc_reg <= pc_reg + 12'd2;
                        4'h9: if (f_n == 4'h0 && !alu_stat.eq) pc_reg <= pc_reg + 12'd2;
                        4'h6, 4'h7: v_reg[f_x] <= alu_stat.res;
                        4'h8:
                        begin
                            // the flag takes vf when x is f
                            if ((f_n <= 4'h3 || flag_op) && !(flag_op && f_x == 4'hF))
                            begin
                                v_reg[f_x] <= alu_stat.res;
                            end
                            if (flag_op)
                            begin
                                v_reg[15] <= {7'b0, alu_stat.flag};
                            end
                        end
                        4'hA: index_reg <= {4'h0, f_nnn};
                        4'hB: pc_reg <= {4'h0, vy_reg} + f_nnn;
                        4'hE:
                        begin
                            if ((f_kk == 8'h9E && key_hit) || (f_kk == 8'hA1 && !key_hit))
                            begin
                                pc_reg <= pc_reg + 12'd2;
                            end
                        end
                        4'hF:
                        begin
                            case (f_kk)
                                8'h07: v_reg[f_x] <= alu_stat.res;
                                8'h0A:
                                begin
                                    if (any_key)
                                    begin
                                        v_reg[f_x] <= alu_stat.res;
                                    end
                                    else
                                    begin
                                        pc_reg <= pc_reg - 12'd2;
                                    end
                                end
                                8'h15: delay_reg <= vx_reg;
                                8'h18: sound_reg <= vx_reg;
                                8'h1E: index_reg <= index_reg + {8'h00, vx_reg};
                                8'h29: index_reg <= 16'(FONT_BASE) + {5'b0, vx_times5};
                                default: index_reg <= index_reg;
                            endcase
                        end
                        default: pc_reg <= pc_reg;
                    endcase
                end
                S_BCD, S_ST: cnt_reg <= cnt_reg + 4'd1;
                S_LD:
                begin
                    ld_phase_reg <= !ld_phase_reg;
                    if (ld_phase_reg)
                    begin
                        v_reg[cnt_reg] <= mem_q;
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // call stack: write on a call, read continuously below the pointer
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC && f_hi == 4'h2)
        begin
            stack_mem[sp_reg] <= pc_reg;
        end
        stack_q_reg <= stack_mem[sp_dec];
    end

    // per-item working and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg <= '0;
            rdata_reg <= '0;
            clr_reg <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        opcode_reg <= '0;
                        rdata_reg <= '0;
                        clr_reg <= 1'b0;
                        wait_reg <= 1'b0;
                    end
                end
                S_RDWAIT: rdata_reg <= mem_q;
                S_F2:     opcode_reg <= {hi_reg, mem_q};
                S_EXEC:
                begin
                    clr_reg <= (opcode_reg == 16'h00E0);
                    wait_reg <= (f_hi == 4'hF) && (f_kk == 8'h0A) && !any_key;
                end
                default: rdata_reg <= rdata_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            keys_reg <= keys;
        end
        if (state_reg == S_F1)
        begin
            hi_reg <= mem_q;
        end
        if (state_reg == S_RX)
        begin
            vx_reg <= rf_rdata;
        end
        if (state_reg == S_RY)
        begin
            vy_reg <= rf_rdata;
        end
    end

    assign pc_value = pc_reg;
    assign opcode_value = opcode_reg;
    assign index_value = index_reg;
    assign read_data = rdata_reg;
    assign delay_value = delay_reg;
    assign sound_value = sound_reg;
    assign clear_screen = clr_reg;
    assign waiting_key = wait_reg;

    // one word in flight: never ready while a result is shown
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // no word is taken before the memory sweep has finished
    a_init_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> init_done)
        else $error("input ready during memory sweep");

    // an instruction needs its fetch cycles before a result appears
    a_exec_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == c8ie_pkg::OP_EXEC) |=> !out_valid ##1 !out_valid)
        else $error("instruction result too early");

    // the stack pointer stays inside the stack
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sp_reg) < STACK_DEPTH)
        else $error("stack pointer out of range");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for chip8_instruction_execute_unit
// depends on c8ie_pkg and the rtl of the execute unit; a class keeps a
// cycle-free model of the core and checks every result word against it
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT = 1000000;
    localparam int NUM_ITEMS = 1400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] pc_value;
    logic [15:0] opcode_value;
    logic [15:0] index_value;
    logic [7:0]  read_data;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic        clear_screen;
    logic        waiting_key;

    chip8_instruction_execute_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .addr         (addr),
        .data         (data),
        .keys         (keys),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pc_value     (pc_value),
        .opcode_value (opcode_value),
        .index_value  (index_value),
        .read_data    (read_data),
        .delay_value  (delay_value),
        .sound_value  (sound_value),
        .clear_screen (clear_screen),
        .waiting_key  (waiting_key)
    );

    // one result word as the core reports it
    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] opc;
        logic [15:0] idx;
        logic [7:0]  rdat;
        logic [7:0]  dly;
        logic [7:0]  snd;
        logic        clr;
        logic        wt;
    } core_status_t;

    // cycle-free copy of the core plus the store of pending status words
    class core_scoreboard;
        logic [7:0]   mem [c8ie_pkg::MEM_DEPTH];
        logic [7:0]   v [16];
        logic [11:0]  pc;
        logic [15:0]  idx;
        logic [11:0]  stk [16];
        bit           stk_set [16];
        logic [3:0]   sp;
        logic [7:0]   dly;
        logic [7:0]   snd;
        core_status_t pending_status [$];
        int           mismatches;
        int           checked;
        int           execs;

        function void reset_state();
            foreach (mem[i]) mem[i] = 8'h00;
            for (int i = 0; i < c8ie_pkg::FONT_LEN; i++)
                mem[c8ie_pkg::FONT_BASE_DEF + i] = c8ie_pkg::GLYPHS[i];
            foreach (v[i]) v[i] = 8'h00;
            foreach (stk_set[i]) stk_set[i] = 0;
            pc = 12'(c8ie_pkg::ROM_START_DEF);
            idx = 16'h0000;
            sp = 4'd0;
            dly = 8'h00;
            snd = 8'h00;
            mismatches = 0;
            checked = 0;
            execs = 0;
        endfunction

        function logic [15:0] word_at_pc();
            return {mem[pc], mem[pc + 12'd1]};
        endfunction

        // a return is legal only when the entry it pops was pushed before
        function bit return_legal();
            return stk_set[sp - 4'd1];
        endfunction

        function bit key_hit(logic [15:0] k, logic [7:0] code);
            return code < 8'd16 && k[code[3:0]];
        endfunction

        // run one instruction word on the model state
        function void run_instr(logic [15:0] w, logic [15:0] k, ref core_status_t s);
            logic [3:0]  x;
            logic [3:0]  y;
            logic [3:0]  n;
            logic [7:0]  kk;
            logic [11:0] nnn;
            logic [7:0]  vx;
            logic [7:0]  vy;
            logic [7:0]  r;
            logic        f;
            bit          flagged;
            x = w[11:8];
            y = w[7:4];
            n = w[3:0];
            kk = w[7:0];
            nnn = w[11:0];
            vx = v[x];
            vy = v[y];
            r = 8'h00;
            f = 1'b0;
            flagged = 0;
            case (w[15:12])
                4'h0: begin
                    if (w == 16'h00E0)
                        s.clr = 1'b1;
                    else if (w == 16'h00EE)
                    begin
                        sp = sp - 4'd1;
                        pc = stk[sp];
                    end
                end
                4'h1: pc = nnn;
                4'h2: begin
                    stk[sp] = pc;
                    stk_set[sp] = 1;
                    sp = sp + 4'd1;
                    pc = nnn;
                end
                4'h3: if (vx == kk) pc = pc + 12'd2;
                4'h4: if (vx != kk) pc = pc + 12'd2;
                4'h5: if (n == 4'h0 && vx == vy) pc = pc + 12'd2;
                4'h6: v[x] = kk;
                4'h7: v[x] = vx + kk;
                4'h8: begin
                    flagged = 1;
                    case (n)
                        4'h0: begin v[x] = vy; flagged = 0; end
                        4'h1: begin v[x] = vx | vy; flagged = 0; end
                        4'h2: begin v[x] = vx & vy; flagged = 0; end
                        4'h3: begin v[x] = vx ^ vy; flagged = 0; end
                        4'h4: {f, r} = {1'b0, vx} + {1'b0, vy};
                        4'h5: begin r = vx - vy; f = vx > vy; end
                        4'h6: begin r = vx >> 1; f = vx[0]; end
                        4'h7: begin r = vy - vx; f = vy > vx; end
                        4'hE: begin r = vx << 1; f = vx[7]; end
                        default: flagged = 0;
                    endcase
                    // flag goes last so it wins when x is f
                    if (flagged)
                    begin
                        v[x] = r;
                        v[15] = {7'b0, f};
                    end
                end
                4'h9: if (n == 4'h0 && vx != vy) pc = pc + 12'd2;
                4'hA: idx = {4'h0, nnn};
                4'hB: pc = {4'h0, v[0]} + nnn;
                4'hE: begin
                    if (kk == 8'h9E && key_hit(k, vx))
                        pc = pc + 12'd2;
                    else if (kk == 8'hA1 && !key_hit(k, vx))
                        pc = pc + 12'd2;
                end
                4'hF: begin
                    case (kk)
                        8'h07: v[x] = dly;
                        8'h0A: begin
                            // highest pressed key wins, none pressed repeats
                            for (int i = 0; i < 16; i++)
                                if (k[i])
                                begin
                                    r = i[7:0];
                                    f = 1'b1;
                                end
                            if (f)
                                v[x] = r;
                            else
                            begin
                                pc = pc - 12'd2;
                                s.wt = 1'b1;
                            end
                        end
                        8'h15: dly = vx;
                        8'h18: snd = vx;
                        8'h1E: idx = idx + {8'h00, vx};
                        8'h29: idx = 16'(c8ie_pkg::FONT_BASE_DEF) + 16'd5 * {8'h00, vx};
                        8'h33: begin
                            mem[idx[11:0]] = vx / 8'd100;
                            mem[idx[11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
                            mem[idx[11:0] + 12'd2] = vx % 8'd10;
                        end
                        8'h55: for (int i = 0; i <= x; i++)
                            mem[idx[11:0] + i[11:0]] = v[i];
                        8'h65: for (int i = 0; i <= x; i++)
                            v[i] = mem[idx[11:0] + i[11:0]];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        endfunction

        // accepted input word: advance the model and queue its status word
        function void note_input(logic [1:0] o, logic [11:0] a, logic [7:0] d,
                                 logic [15:0] k);
            core_status_t s;
            s = '0;
            if (o == c8ie_pkg::OP_EXEC)
            begin
                s.opc = word_at_pc();
                pc = pc + 12'd2;
                execs++;
                run_instr(s.opc, k, s);
            end
            else if (o == c8ie_pkg::OP_WRITE)
                mem[a] = d;
            else if (o == c8ie_pkg::OP_READ)
                s.rdat = mem[a];
            s.pc = pc;
            s.idx = idx;
            s.dly = dly;
            s.snd = snd;
            pending_status.push_back(s);
        endfunction

        function void check_result(core_status_t got);
            core_status_t exp_s;
            checked++;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h at %0t", got, $realtime);
                return;
            end
            exp_s = pending_status.pop_front();
            if (got.pc !== exp_s.pc || got.opc !== exp_s.opc || got.idx !== exp_s.idx
                || got.rdat !== exp_s.rdat || got.dly !== exp_s.dly
                || got.snd !== exp_s.snd || got.clr !== exp_s.clr || got.wt !== exp_s.wt)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch word %0d: pc %h/%h opc %h/%h idx %h/%h rd %h/%h",
                             checked, exp_s.pc, got.pc, exp_s.opc, got.opc,
                             exp_s.idx, got.idx, exp_s.rdat, got.rdat);
                    $display("  dly %h/%h snd %h/%h clr %b/%b wait %b/%b (exp/got)",
                             exp_s.dly, got.dly, exp_s.snd, got.snd,
                             exp_s.clr, got.clr, exp_s.wt, got.wt);
                end
            end
        endfunction
    endclass

    core_scoreboard sb;
    int  cycles;
    int  words_sent;
    bit  no_idle;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: stalls at random, about one time in five, outside the quiet stretch
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    // result words are checked at the rising edge they are taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({pc_value, opcode_value, index_value, read_data,
                             delay_value, sound_value, clear_screen, waiting_key});
    end

    // present one word, hold it until taken, return at the next falling edge
    task automatic send_word(logic [1:0] o, logic [11:0] a, logic [7:0] d,
                             logic [15:0] k);
        while (!no_idle && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        addr <= a;
        data <= d;
        keys <= k;
        do @(posedge clk); while (!in_ready);
        sb.note_input(o, a, d, k);
        words_sent++;
        @(negedge clk);
    endtask

    // place an instruction word at the current pc
    task automatic plant_instr(logic [15:0] w);
        send_word(c8ie_pkg::OP_WRITE, sb.pc, w[15:8], 16'h0000);
        send_word(c8ie_pkg::OP_WRITE, sb.pc + 12'd1, w[7:0], 16'h0000);
    endtask

    // execute at pc, turning a return from an unused stack entry into a clear
    task automatic exec_step(logic [15:0] k);
        if (sb.word_at_pc() == 16'h00EE && !sb.return_legal())
            send_word(c8ie_pkg::OP_WRITE, sb.pc + 12'd1, 8'hE0, 16'h0000);
        send_word(c8ie_pkg::OP_EXEC, 12'($urandom), 8'($urandom), k);
    endtask

    function automatic logic [15:0] rand_keys();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] rand_target();
        case ($urandom_range(0, 7))
            0: return 12'h000;
            1: return 12'hFFE;
            2: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    // random instruction word biased toward defined forms
    function automatic logic [15:0] rand_instr();
        logic [3:0]  hi;
        logic [15:0] w;
        logic [7:0]  f_forms [10];
        logic [3:0]  alu_forms [10];
        f_forms = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
        alu_forms = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE, 4'h0};
        hi = 4'($urandom_range(0, 15));
        w = {hi, 12'($urandom)};
        case (hi)
            4'h0: case ($urandom_range(0, 2))
                0: w = 16'h00E0;
                1: w = 16'h00EE;
                default: ;
            endcase
            4'h1, 4'h2, 4'hB: w[11:0] = rand_target();
            4'h5, 4'h9: if ($urandom_range(0, 3) != 0) w[3:0] = 4'h0;
            4'h8: begin
                w[3:0] = alu_forms[$urandom_range(0, 9)];
                if ($urandom_range(0, 9) == 0) w[3:0] = 4'($urandom);
            end
            4'hE: case ($urandom_range(0, 2))
                0: w[7:0] = 8'h9E;
                1: w[7:0] = 8'hA1;
                default: ;
            endcase
            4'hF: begin
                w[7:0] = f_forms[$urandom_range(0, 9)];
                if (w[7:0] == 8'h00) w[7:0] = 8'($urandom);
            end
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        sb = new();
        sb.reset_state();
        no_idle = 0;
        words_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = c8ie_pkg::OP_EXEC;
        addr = '0;
        data = '0;
        keys = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: memory edges, font, unused op, clear, key wait, pc wrap
        send_word(c8ie_pkg::OP_WRITE, 12'hFFF, 8'hFF, 16'hFFFF);
        send_word(c8ie_pkg::OP_WRITE, 12'h000, 8'h00, 16'h0000);
        send_word(c8ie_pkg::OP_READ, 12'hFFF, 8'h00, 16'h0000);
        send_word(c8ie_pkg::OP_READ, 12'h050, 8'hFF, 16'h0000);
        send_word(c8ie_pkg::OP_READ, 12'h09F, 8'h00, 16'h0000);
        send_word(c8ie_pkg::OP_NOP, 12'hFFF, 8'hFF, 16'hFFFF);
        plant_instr(16'h00E0);
        exec_step(16'h0000);
        plant_instr(16'hF30A);
        exec_step(16'h0000);
        exec_step(16'h8001);
        plant_instr(16'h6FFF);
        exec_step(16'h0000);
        plant_instr(16'h8FF4);
        exec_step(16'h0000);
        plant_instr(16'h1FFE);
        exec_step(16'h0000);
        plant_instr(16'hF333);
        exec_step(16'h0000);
        exec_step(16'h0000);

        // random: mostly planted instructions, some stale memory, some noise
        while (words_sent < NUM_ITEMS)
        begin
            no_idle = (words_sent >= 500 && words_sent < 800);
            case ($urandom_range(0, 19))
                0: send_word(2'($urandom), 12'($urandom), 8'($urandom), 16'($urandom));
                1: send_word(c8ie_pkg::OP_READ, 12'($urandom), 8'($urandom),
                             16'($urandom));
                2: begin
                    // deep call chain and unwind, wraps the stack pointer
                    repeat (18)
                    begin
                        plant_instr({4'h2, 12'($urandom)});
                        exec_step(16'h0000);
                    end
                    repeat (18)
                    begin
                        plant_instr(16'h00EE);
                        exec_step(16'h0000);
                    end
                end
                3, 4, 5, 6: exec_step(rand_keys());
                default: begin
                    plant_instr(rand_instr());
                    exec_step(rand_keys());
                end
            endcase
        end
        in_valid <= 1'b0;
        no_idle = 0;

        while (sb.pending_status.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("%0d input words, %0d instructions run, %0d result words checked",
                 words_sent, sb.execs, sb.checked);
        $display("%0d mismatches over %0d cycles", sb.mismatches, cycles);
        if (sb.mismatches == 0 && sb.pending_status.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
